// File: hdl/assert_macros.svh
// assertion macros shared by the record list design
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define SQKE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// condition on one edge that forces a consequence on the next edge
`define SQKE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/sqke_pkg.sv
// shared types and constants of the record list design
package sqke_pkg;

    localparam int DEPTH_DEF = 16;
    localparam int ID_W      = 32;
    localparam int SER_W     = 32;
    localparam int MAK_W     = 16;
    localparam int FILL_W    = 5;
    localparam int CMD_W     = 2;

    localparam logic [CMD_W-1:0] CMD_PUSH    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_PUT     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_POP     = 2'd2;
    localparam logic [CMD_W-1:0] CMD_EXTRACT = 2'd3;

    typedef enum logic [1:0] {
        K_PUSH,
        K_PUT,
        K_POP,
        K_EXTRACT
    } t_kind;

    typedef struct packed {
        logic signed [ID_W-1:0]  id;
        logic signed [SER_W-1:0] serial;
        logic [MAK_W-1:0]        maker;
    } t_rec;

    typedef struct packed {
        t_kind kind;
        t_rec  rec;
    } t_op;

    typedef struct packed {
        logic                    found;
        logic signed [ID_W-1:0]  id;
        logic signed [SER_W-1:0] serial;
        logic [MAK_W-1:0]        maker;
        logic                    overflow;
        logic [FILL_W-1:0]       fill;
    } t_res;

endpackage

// File: hdl/sqke_ifs.sv
// command and result channel interfaces
interface sqke_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [sqke_pkg::CMD_W-1:0]          command;
    logic signed [sqke_pkg::ID_W-1:0]    entry_id;
    logic signed [sqke_pkg::SER_W-1:0]   entry_serial;
    logic [sqke_pkg::MAK_W-1:0]          maker_handle;

    modport source (output valid, command, entry_id, entry_serial, maker_handle,
                    input ready);
    modport sink   (input valid, command, entry_id, entry_serial, maker_handle,
                    output ready);
endinterface

interface sqke_res_if;
    logic                                valid;
    logic                                ready;
    logic                                found;
    logic signed [sqke_pkg::ID_W-1:0]    result_id;
    logic signed [sqke_pkg::SER_W-1:0]   result_serial;
    logic [sqke_pkg::MAK_W-1:0]          result_maker;
    logic                                overflow;
    logic [sqke_pkg::FILL_W-1:0]         fill_count;

    modport source (output valid, found, result_id, result_serial, result_maker,
                    overflow, fill_count, input ready);
    modport sink   (input valid, found, result_id, result_serial, result_maker,
                    overflow, fill_count, output ready);
endinterface

// File: hdl/stack_queue_with_keyed_extract_unit.sv
// top level of the bounded record list with stack, queue and keyed extract
//
//  channel | dir | role            | fields
//  i_cmd   | in  | command stream  | command, entry_id, entry_serial, maker_handle
//  o_res   | out | one result each | found, result_id, result_serial, result_maker,
//          |     |                 | overflow, fill_count
//
// push, put and pop are done in the list stage when it accepts them, extract runs a
// registered parallel compare over all lanes, then the shift that closes the gap
// a command passes the intake register and the queue before it reaches the list,
// whose result register feeds o_res; an extract also passes the search state.
// i_rst_n is synchronous; it empties the list and all handshake state
// the command queue lets intake continue while a result waits on o_res
module stack_queue_with_keyed_extract_unit #(
    parameter int DEPTH = sqke_pkg::DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sqke_cmd_if.sink   i_cmd,
    sqke_res_if.source o_res
);
    import sqke_pkg::*;

    // intake register to queue
    logic f_valid;
    logic f_ready;
    t_op  f_op;

    // queue to list stage
    logic q_valid;
    logic q_ready;
    t_op  q_op;

    // list stage result register
    logic b_valid;
    t_res b_res;

    // decode of each command transaction
    sqke_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (i_cmd),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_op    (f_op)
    );

    // decoupling queue, lets intake and list stall independently
    sqke_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_op    (f_op),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_op    (q_op)
    );

    // record chain, search and result register
    sqke_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .o_ready     (q_ready),
        .i_op        (q_op),
        .o_valid     (b_valid),
        .i_res_ready (o_res.ready),
        .o_res       (b_res)
    );

    // result fields onto the outgoing channel
    assign o_res.valid         = b_valid;
    assign o_res.found         = b_res.found;
    assign o_res.result_id     = b_res.id;
    assign o_res.result_serial = b_res.serial;
    assign o_res.result_maker  = b_res.maker;
    assign o_res.overflow      = b_res.overflow;
    assign o_res.fill_count    = b_res.fill;

endmodule

// File: hdl/sqke_front.sv
// command intake: decodes each transaction into an operation record
module sqke_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    sqke_cmd_if.sink                     i_cmd,
    output logic                         o_valid,
    input  logic                         i_ready,
    output sqke_pkg::t_op                o_op
);
    import sqke_pkg::*;

    logic r_valid;
    t_op  r_op;
    t_op  n_op;
    logic take;

    assign i_cmd.ready = !r_valid || i_ready;
    assign take        = i_cmd.valid && i_cmd.ready;
    assign o_valid     = r_valid;
    assign o_op        = r_op;

    always_comb begin
        n_op.rec.id     = i_cmd.entry_id;
        n_op.rec.serial = i_cmd.entry_serial;
        n_op.rec.maker  = i_cmd.maker_handle;
        case (i_cmd.command)
            CMD_PUSH:    n_op.kind = K_PUSH;
            CMD_PUT:     n_op.kind = K_PUT;
            CMD_POP:     n_op.kind = K_POP;
            CMD_EXTRACT: n_op.kind = K_EXTRACT;
            default:     n_op.kind = K_POP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_op <= n_op;
        end
    end

endmodule

// File: hdl/sqke_fifo.sv
// two-entry operation queue between intake and execution
module sqke_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  sqke_pkg::t_op i_op,
    output logic          o_valid,
    input  logic          i_ready,
    output sqke_pkg::t_op o_op
);
    import sqke_pkg::*;

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_op    = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= !r_wp;
            end
            if (pop) begin
                r_rp <= !r_rp;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_op;
        end
    end

endmodule

// File: hdl/sqke_back.sv
// record list: register chain with shift, keyed search and result register
`include "assert_macros.svh"

module sqke_back #(
    parameter int DEPTH = sqke_pkg::DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  sqke_pkg::t_op  i_op,
    output logic           o_valid,
    input  logic           i_res_ready,
    output sqke_pkg::t_res o_res
);
    import sqke_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } t_state;

    t_state           r_state;
    t_rec             r_list [DEPTH];
    t_rec             n_list [DEPTH];
    logic [CW-1:0]    r_cnt;
    logic [CW-1:0]    n_cnt;
    logic [DEPTH-1:0] r_hit;
    logic [DEPTH-1:0] n_hit;
    logic [DEPTH-1:0] low;
    logic [DEPTH-1:0] ge;
    logic [DEPTH-1:0] sd;
    t_op              r_op;
    logic             r_ovalid;
    t_res             r_res;
    t_rec             sel;
    logic             out_free;
    logic             take;
    logic             full;
    logic             empty;
    logic             do_up;
    logic             do_tail;
    logic             do_pop;
    logic             fin;
    logic             fin_hit;
    logic [CW+FILL_W-1:0] fill_ext;

    assign out_free = !r_ovalid || i_res_ready;
    assign o_ready  = (r_state == S_IDLE) && out_free;
    assign take     = i_valid && o_ready;
    assign full     = (r_cnt == CW'(DEPTH));
    assign empty    = (r_cnt == '0);
    assign do_up    = take && (i_op.kind == K_PUSH) && !full;
    assign do_tail  = take && (i_op.kind == K_PUT) && !full;
    assign do_pop   = take && (i_op.kind == K_POP) && !empty;
    assign fin      = (r_state == S_SEARCH) && out_free;
    assign fin_hit  = fin && (r_hit != '0);

    // first hit isolated, then every lane at or above it
    assign low = r_hit & (~r_hit + DEPTH'(1));
    assign ge  = ~low + DEPTH'(1);
    assign sd  = do_pop ? '1 : (fin ? ge : '0);

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_hit[i] = (CW'(i) < r_cnt) && (r_list[i].id == i_op.rec.id);
        end
    end

    always_comb begin
        sel = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (low[i]) begin
                sel = sel | r_list[i];
            end
        end
    end

    always_comb begin
        n_list = r_list;
        if (do_up) begin
            n_list[0] = i_op.rec;
        end
        if (do_tail && (r_cnt == '0)) begin
            n_list[0] = i_op.rec;
        end
        for (int i = 1; i < DEPTH; i++) begin
            if (do_up) begin
                n_list[i] = r_list[i-1];
            end
            if (do_tail && (CW'(i) == r_cnt)) begin
                n_list[i] = i_op.rec;
            end
        end
        for (int i = 0; i < DEPTH - 1; i++) begin
            if (sd[i]) begin
                n_list[i] = r_list[i+1];
            end
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (do_up || do_tail) begin
            n_cnt = r_cnt + CW'(1);
        end else if (do_pop || fin_hit) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    assign fill_ext = {{FILL_W{1'b0}}, n_cnt};

    always_ff @(posedge i_clk) begin
        r_list <= n_list;
        if (take) begin
            r_op  <= i_op;
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_res    <= '0;
        end else begin
            r_cnt <= n_cnt;
            case (r_state)
                S_IDLE: begin
                    if (take) begin
                        r_res.found    <= do_pop;
                        r_res.id       <= do_pop ? r_list[0].id : '1;
                        r_res.serial   <= do_pop ? r_list[0].serial : '1;
                        r_res.maker    <= do_pop ? r_list[0].maker : '0;
                        r_res.overflow <= full &&
                                          (i_op.kind == K_PUSH || i_op.kind == K_PUT);
                        r_res.fill     <= fill_ext[FILL_W-1:0];
                        if (i_op.kind == K_EXTRACT) begin
                            r_state  <= S_SEARCH;
                            r_ovalid <= 1'b0;
                        end else begin
                            r_ovalid <= 1'b1;
                        end
                    end else if (i_res_ready) begin
                        r_ovalid <= 1'b0;
                    end
                end
                S_SEARCH: begin
                    if (fin) begin
                        r_res.found    <= fin_hit;
                        r_res.id       <= fin_hit ? sel.id : '1;
                        r_res.serial   <= fin_hit ? sel.serial : '1;
                        r_res.maker    <= fin_hit ? sel.maker : '0;
                        r_res.overflow <= 1'b0;
                        r_res.fill     <= fill_ext[FILL_W-1:0];
                        r_ovalid       <= 1'b1;
                        r_state        <= S_IDLE;
                    end else if (i_res_ready) begin
                        r_ovalid <= 1'b0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    `SQKE_ASSERT(a_cnt_bound, r_cnt <= CW'(DEPTH), "record count beyond depth")
    `SQKE_ASSERT(a_search_kind, (r_state != S_SEARCH) || (r_op.kind == K_EXTRACT),
        "search state without an extract")
    `SQKE_ASSERT_NEXT(a_extract_search, take && (i_op.kind == K_EXTRACT),
        r_state == S_SEARCH, "extract did not enter search")
    `SQKE_ASSERT(a_found_ovf, !(r_ovalid && r_res.found && r_res.overflow),
        "result both found and overflow")

endmodule
